FILE: src/vn_pkg.sv
// Shared widths, constants and payload types for the vector normalizer.
package vn_pkg;
	localparam int COMPONENT_WIDTH = 16;
	localparam int SUM_W = 2 * COMPONENT_WIDTH;
	localparam int ACC_W = SUM_W + 38;
	localparam int Q_W = 17;
	localparam int N_STEP = 16;
	localparam int UNIT_W = 16;
	localparam int FRAC_SHIFT = 32;
	localparam logic [UNIT_W-1:0] UNIT_MAX = {1'b0, {(UNIT_W-1){1'b1}}};

	typedef struct packed {
		logic signed [COMPONENT_WIDTH-1:0] comp_x;
		logic signed [COMPONENT_WIDTH-1:0] comp_y;
		logic signed [COMPONENT_WIDTH-1:0] comp_z;
	} vec_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] unit_x;
		logic signed [UNIT_W-1:0] unit_y;
		logic signed [UNIT_W-1:0] unit_z;
		logic                     zero_length;
	} unit_t;

	typedef struct packed {
		logic                  zero;
		logic [2:0]            neg;
		logic [SUM_W-1:0]      sum;
		logic [2:0][SUM_W-1:0] sq;
	} prep_t;

	typedef struct packed {
		logic                  zero;
		logic [2:0]            neg;
		logic [SUM_W-1:0]      sum;
		logic [2:0][SUM_W-1:0] sq;
		logic [2:0][ACC_W-1:0] acc;
		logic [2:0][ACC_W-1:0] lin;
		logic [2:0][Q_W-1:0]   q;
	} srch_t;
endpackage

FILE: src/vn_prep.sv
// Front stages: magnitudes, squares and sum of squares.
module vn_prep import vn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  vld,
	input  vec_t  vec,
	output logic  res_valid,
	output prep_t res
);
	logic [2:0][COMPONENT_WIDTH-1:0] comp;
	logic [2:0][COMPONENT_WIDTH-1:0] mag;
	logic [2:0][COMPONENT_WIDTH-1:0] mag_s1;
	logic [2:0]                      neg_s1, neg_s2;
	logic [2:0][SUM_W-1:0]           sq_s2;
	logic                            valid_s1, valid_s2, valid_s3;
	prep_t                           res_s3;

	assign comp[0] = vec.comp_x;
	assign comp[1] = vec.comp_y;
	assign comp[2] = vec.comp_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = comp[i][COMPONENT_WIDTH-1] ? (~comp[i] + 1'b1) : comp[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= vld;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[i][COMPONENT_WIDTH-1];
				sq_s2[i]  <= SUM_W'(mag_s1[i]) * SUM_W'(mag_s1[i]);
			end
			neg_s2      <= neg_s1;
			res_s3.neg  <= neg_s2;
			res_s3.sq   <= sq_s2;
			res_s3.sum  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			res_s3.zero <= (sq_s2[0] | sq_s2[1] | sq_s2[2]) == '0;
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;
endmodule

FILE: src/vn_search.sv
// Bit-serial search for round(|c| * 2^15 / sqrt(S)), one result bit per stage.
module vn_search import vn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  pin_valid,
	input  prep_t pin,
	output logic  sout_valid,
	output srch_t sout
);
	srch_t             init;
	srch_t             srch_s [1:N_STEP];
	logic [N_STEP:1]   vld_s;

	always_comb begin
		init.zero = pin.zero;
		init.neg  = pin.neg;
		init.sum  = pin.sum;
		init.sq   = pin.sq;
		for (int i = 0; i < 3; i++) begin
			init.acc[i] = ACC_W'(pin.sum);
			init.lin[i] = ~ACC_W'(pin.sum) + 1'b1;
			init.q[i]   = '0;
		end
	end

	for (genvar j = 0; j < N_STEP; j++) begin : g_step
		localparam int K = N_STEP - 1 - j;
		srch_t prev, nxt;
		logic  prev_vld;

		if (j == 0) begin : g_first
			assign prev     = init;
			assign prev_vld = pin_valid;
		end else begin : g_rest
			assign prev     = srch_s[j];
			assign prev_vld = vld_s[j];
		end

		always_comb begin
			logic signed [ACC_W-1:0] cand;
			logic signed [ACC_W-1:0] tgt;
			nxt = prev;
			for (int i = 0; i < 3; i++) begin
				cand = $signed(prev.acc[i]) + ($signed(prev.lin[i]) <<< (K + 2))
					+ $signed(ACC_W'(prev.sum) << (2 * K + 2));
				tgt  = $signed(ACC_W'(prev.sq[i]) << FRAC_SHIFT);
				if (cand <= tgt) begin
					nxt.acc[i] = cand;
					nxt.lin[i] = prev.lin[i] + (ACC_W'(prev.sum) << (K + 1));
					nxt.q[i]   = prev.q[i] | (Q_W'(1) << K);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				srch_s[j+1] <= nxt;
			end
		end
	end

	assign sout_valid = vld_s[N_STEP];
	assign sout       = srch_s[N_STEP];
endmodule

FILE: src/vector3_normalizer.sv
// Top level: pipelined 3D vector normalizer with Q1.15 unit-vector output.
//  channel | valid      | stall      | payload
//  vec     | vec_valid  | vec_stall  | vec  (comp_x, comp_y, comp_z)
//  unit    | unit_valid | unit_stall | unit (unit_x, unit_y, unit_z, zero_length)
// One transfer per cycle while the output is not stalled. Pipeline: 3 front stages,
// 16 search stages (one result bit each), 1 output register.
// Reset clears only the stage valid bits.
// A held result at the output freezes the whole pipeline; vec_stall follows it.
module vector3_normalizer import vn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vec_valid,
	output logic  vec_stall,
	input  vec_t  vec,
	output logic  unit_valid,
	input  logic  unit_stall,
	output unit_t unit
);
	logic              adv;
	logic              prep_valid, srch_valid;
	prep_t             prep;
	srch_t             srch;
	logic [2:0][UNIT_W-1:0] u;
	logic              valid_s20;
	unit_t             unit_s20;

	assign adv       = !(valid_s20 && unit_stall);
	assign vec_stall = !adv;

	vn_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld       (vec_valid),
		.vec       (vec),
		.res_valid (prep_valid),
		.res       (prep)
	);

	vn_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.pin_valid  (prep_valid),
		.pin        (prep),
		.sout_valid (srch_valid),
		.sout       (srch)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (srch.zero) begin
				u[i] = '0;
			end else if (srch.neg[i]) begin
				u[i] = UNIT_W'(~srch.q[i] + 1'b1);
			end else if (srch.q[i] > Q_W'(UNIT_MAX)) begin
				u[i] = UNIT_MAX;
			end else begin
				u[i] = srch.q[i][UNIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s20 <= 1'b0;
		end else if (adv) begin
			valid_s20 <= srch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_s20.unit_x      <= u[0];
			unit_s20.unit_y      <= u[1];
			unit_s20.unit_z      <= u[2];
			unit_s20.zero_length <= srch.zero;
		end
	end

	assign unit_valid = valid_s20;
	assign unit       = unit_s20;
endmodule

FILE: src/vn_chk.sv
// Port-level checker for the vector normalizer, bound to the top level.
module vn_chk import vn_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  vec_valid,
	input logic  vec_stall,
	input vec_t  vec,
	input logic  unit_valid,
	input logic  unit_stall,
	input unit_t unit
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_stall |=> unit_valid && $stable(unit))
		else $error("stalled result changed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall |-> unit_valid && unit_stall)
		else $error("input stalled without output back-pressure");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit.zero_length |->
		unit.unit_x == '0 && unit.unit_y == '0 && unit.unit_z == '0)
		else $error("zero vector gave nonzero components");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !unit.zero_length |->
		unit.unit_x != '0 || unit.unit_y != '0 || unit.unit_z != '0)
		else $error("nonzero vector gave all-zero result");
endmodule

bind vector3_normalizer vn_chk u_chk (.*);

FILE: dv/vector3_normalizer_checker.sv
// Checker for the vector normalizer: predicts unit vectors and compares each output transfer.
module vector3_normalizer_checker import vn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vec_valid,
	input  logic  vec_stall,
	input  vec_t  vec,
	input  logic  unit_valid,
	input  logic  unit_stall,
	input  unit_t unit,
	output int    pending,
	output int    fail_count
);
	unit_t expected_units[$];

	// round(mag * 2^15 / sqrt(sum)), ties away from zero
	function automatic logic [16:0] scaled_mag(logic [16:0] mag, logic [33:0] sum);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [127:0] t;
		int lo;
		int hi;
		int mid;
		rhs = 128'(mag) * 128'(mag);
		rhs = rhs << 32;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 128'(2 * mid - 1);
			lhs = t * t * 128'(sum);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return 17'(lo);
	endfunction

	function automatic unit_t normalize(vec_t v);
		unit_t u;
		logic signed [COMPONENT_WIDTH-1:0] c[3];
		logic [16:0] mag[3];
		logic [16:0] q;
		logic [33:0] sum;
		logic signed [UNIT_W-1:0] r[3];
		c[0] = v.comp_x;
		c[1] = v.comp_y;
		c[2] = v.comp_z;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = c[i] < 0 ? 17'(-18'(c[i])) : 17'(c[i]);
			sum += 34'(mag[i]) * 34'(mag[i]);
		end
		for (int i = 0; i < 3; i++) begin
			r[i] = '0;
			if (sum != 0) begin
				q = scaled_mag(mag[i], sum);
				if (c[i] < 0) r[i] = UNIT_W'(-q);
				else r[i] = q > 17'd32767 ? UNIT_MAX : UNIT_W'(q);
			end
		end
		u.unit_x = r[0];
		u.unit_y = r[1];
		u.unit_z = r[2];
		u.zero_length = (sum == 0);
		return u;
	endfunction

	task automatic report(string field, int exp_v, int act_v);
		$display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = expected_units.size();

	always @(posedge clk) begin
		unit_t e;
		if (arst_n) begin
			if (vec_valid && !vec_stall) expected_units.push_back(normalize(vec));
			if (unit_valid && !unit_stall) begin
				if (expected_units.size() == 0) begin
					$display("%0t: unexpected transfer x=%0d y=%0d z=%0d zero=%0b", $time,
						unit.unit_x, unit.unit_y, unit.unit_z, unit.zero_length);
					fail_count++;
				end else begin
					e = expected_units.pop_front();
					if (e.unit_x !== unit.unit_x) report("unit_x", e.unit_x, unit.unit_x);
					if (e.unit_y !== unit.unit_y) report("unit_y", e.unit_y, unit.unit_y);
					if (e.unit_z !== unit.unit_z) report("unit_z", e.unit_z, unit.unit_z);
					if (e.zero_length !== unit.zero_length)
						report("zero_length", e.zero_length, unit.zero_length);
				end
			end
		end
	end
endmodule

FILE: dv/vector3_normalizer_tb.sv
// Testbench top for the vector normalizer: stimulus, flow control and verdict.
module vector3_normalizer_tb;
	import vn_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  vec_valid = 1'b0;
	logic  vec_stall;
	vec_t  vec = '0;
	logic  unit_valid;
	logic  unit_stall = 1'b0;
	unit_t unit;
	int    pending;
	int    fail_count;
	int    send_idle_pct = 0;
	int    stall_pct = 0;
	int    cycles = 0;

	vector3_normalizer uut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.unit_valid(unit_valid), .unit_stall(unit_stall), .unit(unit)
	);

	vector3_normalizer_checker chk (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.unit_valid(unit_valid), .unit_stall(unit_stall), .unit(unit),
		.pending(pending), .fail_count(fail_count)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		unit_stall <= ($urandom_range(0, 99) < stall_pct);
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			vec_valid <= 1'b0;
			@(posedge clk);
		end
		vec_valid <= 1'b1;
		vec <= {x, y, z};
		@(posedge clk);
		while (vec_stall) @(posedge clk);
	endtask

	task automatic drain();
		vec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_comp(int kind);
		case (kind)
			0: return 16'($urandom_range(0, 15)) - 16'd8;
			1: return 16'($urandom_range(0, 511)) - 16'd256;
			2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			3: return 16'h0;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int kind;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, axes, zero vector, full-scale negative
		send_vec(16'h0, 16'h0, 16'h0);
		send_vec(16'h7fff, 16'h0, 16'h0);
		send_vec(16'h0, 16'h7fff, 16'h0);
		send_vec(16'h0, 16'h0, 16'h7fff);
		send_vec(16'h8000, 16'h0, 16'h0);
		send_vec(16'h0, 16'h8000, 16'h0);
		send_vec(16'h0, 16'h0, 16'h8000);
		send_vec(16'h1, 16'h0, 16'h0);
		send_vec(16'hffff, 16'h0, 16'h0);
		send_vec(16'h8000, 16'h8000, 16'h8000);
		send_vec(16'h7fff, 16'h7fff, 16'h7fff);
		send_vec(16'h7fff, 16'h8000, 16'h7fff);
		send_vec(16'h1, 16'h1, 16'h1);
		send_vec(16'hffff, 16'h1, 16'hffff);
		send_vec(16'h3, 16'h4, 16'h0);
		send_vec(16'h1, 16'h2, 16'h2);
		send_vec(16'h8000, 16'h1, 16'h0);
		send_vec(16'h5555, 16'haaaa, 16'h0);
		send_vec(16'h0, 16'h0, 16'h0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 87 : 24) : 0;
			stall_pct = (phase == 2) ? 87 : (phase == 3 ? 24 : 0);
			for (int n = 0; n < 120; n++) begin
				kind = $urandom_range(0, 9);
				send_vec(rand_comp(kind), rand_comp(kind > 4 ? 4 : $urandom_range(0, 4)),
					rand_comp($urandom_range(0, 6)));
			end
			drain();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

FILE: vector3_normalizer.f
src/vn_pkg.sv
src/vn_prep.sv
src/vn_search.sv
src/vector3_normalizer.sv
src/vn_chk.sv
dv/vector3_normalizer_checker.sv
dv/vector3_normalizer_tb.sv
